// File: rtl/core/nne_pkg.sv
// shared types and constants for the negacyclic ntt engine
package nne_pkg;

  localparam int WORD_BITS = 32;
  localparam int STEP_CNT_W = 5;
  localparam int INDEX_BITS = 10;
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [3:0] LOG_SIZE_RESET = 4'd10;
  localparam logic [WORD_BITS-1:0] MODULUS_MIN = 32'd3;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_INVERSE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODULUS      = 3'd0,
    REG_ROOT_PSI     = 3'd1,
    REG_ROOT_PSI_INV = 3'd2,
    REG_SIZE_INV     = 3'd3,
    REG_LOG_SIZE     = 3'd4
  } reg_index_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [INDEX_BITS-1:0] index;
    logic [WORD_BITS-1:0]  coeff_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] coeff_out;
    kind_t                kind;
  } out_item_t;

endpackage

// File: rtl/core/nne_ram.sv
// generic single write port, single read port ram with registered read
module nne_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/negacyclic_ntt_engine.sv
// negacyclic ntt engine top level: coefficient store, twiddle store, butterfly sequencer
//
// input channel in_valid/in_ready/in_data carries commands: write coefficient,
// forward transform, inverse transform, read coefficient
// output channel out_valid/out_ready/out_data returns read data (kind 0) or a
// transform done marker (kind 1, coeff_out zero); writes return nothing
// cfg_we/cfg_index/cfg_wdata load modulus, psi, psi inverse, n inverse, log size
// a write finishes on its transfer; a read passes through S_RD, where an output stall can hold it
// a transform first fills the twiddle store: one multiply per entry, n entries
// each butterfly then takes two multiplies forward and three inverse,
// (n/2)log2(n) butterflies, all on the single bit-serial modular
// multiplier (optional 32 reduction steps, then 32 multiply steps)
// the inverse adds one multiply per coefficient for the n inverse scaling
// one command is in flight at a time; a finished result sits in the output
// register and a write may transfer while it waits
// when the receiver stalls, a read or transform holds in its last step until
// the output register frees up
// reset clears control state and restores register defaults; store contents
// are undefined until written
module negacyclic_ntt_engine #(
  parameter int MAX_SIZE   = 1024,
  parameter int COEFF_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  nne_pkg::in_item_t                       in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output nne_pkg::out_item_t                      out_data,
  input  logic                                    cfg_we,
  input  logic [nne_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [nne_pkg::WORD_BITS-1:0]           cfg_wdata
);

  import nne_pkg::*;

  localparam int AW = $clog2(MAX_SIZE);
  localparam int CW = AW + 1;
  localparam int DW = $clog2(AW + 1);
  localparam logic [WORD_BITS-1:0] CoeffMask = (COEFF_BITS >= WORD_BITS) ? '1 :
      WORD_BITS'((64'd1 << COEFF_BITS) - 64'd1);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_RD    = 19'h00002,
    S_FILL  = 19'h00004,
    S_FILLW = 19'h00008,
    S_BRD   = 19'h00010,
    S_BHI   = 19'h00020,
    S_BLO   = 19'h00040,
    S_FW1   = 19'h00080,
    S_FW2   = 19'h00100,
    S_IV1   = 19'h00200,
    S_IV2   = 19'h00400,
    S_IV3   = 19'h00800,
    S_IV4   = 19'h01000,
    S_WLO   = 19'h02000,
    S_WHI   = 19'h04000,
    S_SC0   = 19'h08000,
    S_SC1   = 19'h10000,
    S_SC2   = 19'h20000,
    S_DONE  = 19'h40000
  } state_t;

  // configuration registers
  logic [WORD_BITS-1:0] modulus_r, root_psi_r, root_psi_inv_r, size_inv_r;
  logic [3:0]           log_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r      <= MODULUS_MIN;
      root_psi_r     <= '0;
      root_psi_inv_r <= '0;
      size_inv_r     <= '0;
      log_size_r     <= LOG_SIZE_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MODULUS:      modulus_r      <= cfg_wdata;
        REG_ROOT_PSI:     root_psi_r     <= cfg_wdata;
        REG_ROOT_PSI_INV: root_psi_inv_r <= cfg_wdata;
        REG_SIZE_INV:     size_inv_r     <= cfg_wdata;
        REG_LOG_SIZE:     log_size_r     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  logic [WORD_BITS-1:0] q_eff;
  logic [DW-1:0]        d_eff;
  logic [CW-1:0]        n_eff;

  always_comb begin
    q_eff = (modulus_r < MODULUS_MIN) ? MODULUS_MIN : modulus_r;
    if (log_size_r == 4'd0) begin
      d_eff = DW'(1);
    end else if (int'(log_size_r) > AW) begin
      d_eff = DW'(AW);
    end else begin
      d_eff = DW'(log_size_r);
    end
    n_eff = CW'(1) << d_eff;
  end

  // bit-serial modular multiplier: optional operand reduction, then msb-first multiply
  logic                  mm_start, mm_reduce;
  logic [WORD_BITS-1:0]  mm_a, mm_b;
  logic                  mm_busy_r, mm_phase_r, mm_domul_r;
  logic [STEP_CNT_W-1:0] mm_cnt_r;
  logic [WORD_BITS-1:0]  mm_src_r, mm_b_r, mm_red_r, mm_acc_r;
  logic [WORD_BITS-1:0]  mm_res;
  logic [WORD_BITS:0]    red_step, dbl_step, add_step;
  logic [WORD_BITS-1:0]  red_next, dbl_red, acc_next;

  always_comb begin
    red_step = {mm_red_r, mm_src_r[WORD_BITS-1]};
    red_next = (red_step >= {1'b0, q_eff}) ? WORD_BITS'(red_step - {1'b0, q_eff}) :
                                             red_step[WORD_BITS-1:0];
    dbl_step = {mm_acc_r, 1'b0};
    dbl_red  = (dbl_step >= {1'b0, q_eff}) ? WORD_BITS'(dbl_step - {1'b0, q_eff}) :
                                             dbl_step[WORD_BITS-1:0];
    add_step = {1'b0, dbl_red} + (mm_b_r[WORD_BITS-1] ? {1'b0, mm_red_r} : '0);
    acc_next = (add_step >= {1'b0, q_eff}) ? WORD_BITS'(add_step - {1'b0, q_eff}) :
                                             add_step[WORD_BITS-1:0];
    mm_res   = mm_domul_r ? mm_acc_r : mm_red_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_busy_r <= 1'b0;
    end else if (mm_start) begin
      mm_busy_r  <= 1'b1;
      mm_phase_r <= !mm_reduce;
      mm_domul_r <= 1'b1;
      mm_cnt_r   <= '0;
      mm_src_r   <= mm_a;
      mm_b_r     <= mm_b;
      mm_red_r   <= mm_reduce ? '0 : mm_a;
      mm_acc_r   <= '0;
    end else if (mm_busy_r) begin
      mm_cnt_r <= mm_cnt_r + 1'b1;
      if (!mm_phase_r) begin
        mm_red_r <= red_next;
        mm_src_r <= mm_src_r << 1;
        if (&mm_cnt_r) begin
          mm_phase_r <= 1'b1;
          mm_busy_r  <= mm_domul_r;
        end
      end else begin
        mm_acc_r <= acc_next;
        mm_b_r   <= mm_b_r << 1;
        if (&mm_cnt_r) begin
          mm_busy_r <= 1'b0;
        end
      end
    end
  end

  // memories
  logic                 cs_we, cs_re, tw_we, tw_re;
  logic [AW-1:0]        cs_waddr, cs_raddr, tw_waddr, tw_raddr;
  logic [WORD_BITS-1:0] cs_wdata, cs_rdata, tw_rdata;

  nne_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_SIZE)) u_coeff_ram (
    .clk     (clk),
    .wr_en   (cs_we),
    .wr_addr (cs_waddr),
    .wr_data (cs_wdata),
    .rd_en   (cs_re),
    .rd_addr (cs_raddr),
    .rd_data (cs_rdata)
  );

  nne_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_SIZE)) u_twiddle_ram (
    .clk     (clk),
    .wr_en   (tw_we),
    .wr_addr (tw_waddr),
    .wr_data (mm_src_r),
    .rd_en   (tw_re),
    .rd_addr (tw_raddr),
    .rd_data (tw_rdata)
  );

  // sequencer
  state_t               state_r, state_nxt;
  logic                 fwd_r, fwd_nxt;
  logic                 rd_oob_r, rd_oob_nxt;
  logic [CW-1:0]        k_r, k_nxt, g_r, g_nxt, t_r, t_nxt;
  logic [CW-1:0]        i_r, i_nxt, j_r, j_nxt, base_r, base_nxt;
  logic [WORD_BITS-1:0] p_r, p_nxt, hi_r, hi_nxt, s_r, s_nxt;
  logic [WORD_BITS-1:0] u_r, u_nxt, v_r, v_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 in_xfer, out_free, idx_ok;
  logic [AW-1:0]        idx_addr, lo_addr, hi_addr, k_rev;
  logic [WORD_BITS-1:0] sum_c, diff_c, qmv;
  logic                 last_j, last_i;

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      k_rev[b] = k_r[AW-1-b];
    end
    k_rev = k_rev >> (AW - int'(d_eff));
  end

  always_comb begin
    qmv    = q_eff - v_r;
    sum_c  = (u_r >= qmv) ? u_r - qmv : u_r + v_r;
    diff_c = (u_r >= v_r) ? u_r - v_r : u_r + qmv;
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign idx_ok   = {{(WORD_BITS-INDEX_BITS){1'b0}}, in_data.index} < WORD_BITS'(MAX_SIZE);
  assign idx_addr = AW'(in_data.index);
  assign lo_addr  = AW'(base_r + j_r);
  assign hi_addr  = AW'(base_r + j_r + t_r);
  assign last_j   = (j_r == t_r - 1'b1);
  assign last_i   = (i_r == g_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    fwd_nxt       = fwd_r;
    rd_oob_nxt    = rd_oob_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    t_nxt         = t_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    base_nxt      = base_r;
    p_nxt         = p_r;
    hi_nxt        = hi_r;
    s_nxt         = s_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mm_start      = 1'b0;
    mm_reduce     = 1'b0;
    mm_a          = '0;
    mm_b          = '0;
    cs_we         = 1'b0;
    cs_waddr      = lo_addr;
    cs_wdata      = sum_c;
    cs_re         = 1'b0;
    cs_raddr      = hi_addr;
    tw_we         = 1'b0;
    tw_waddr      = k_rev;
    tw_re         = 1'b0;
    tw_raddr      = AW'(g_r + i_r);

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.cmd)
            CMD_WRITE: begin
              cs_we    = idx_ok;
              cs_waddr = idx_addr;
              cs_wdata = in_data.coeff_in & CoeffMask;
            end
            CMD_READ: begin
              cs_re      = 1'b1;
              cs_raddr   = idx_addr;
              rd_oob_nxt = !idx_ok;
              state_nxt  = S_RD;
            end
            default: begin
              fwd_nxt   = (in_data.cmd == CMD_FORWARD);
              k_nxt     = '0;
              p_nxt     = WORD_BITS'(1);
              state_nxt = S_FILL;
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.coeff_out = rd_oob_r ? '0 : cs_rdata;
          out_data_nxt.kind      = KIND_READ;
          state_nxt              = S_IDLE;
        end
      end
      S_FILL: begin
        mm_start  = 1'b1;
        mm_a      = p_r;
        mm_b      = fwd_r ? root_psi_r : root_psi_inv_r;
        state_nxt = S_FILLW;
      end
      S_FILLW: begin
        // twiddle ram writes from the multiplier source register holding psi^k
        if (!mm_busy_r) begin
          tw_we = 1'b1;
          p_nxt = mm_res;
          k_nxt = k_r + 1'b1;
          if (k_r == n_eff - 1'b1) begin
            g_nxt     = fwd_r ? CW'(1) : (n_eff >> 1);
            t_nxt     = fwd_r ? (n_eff >> 1) : CW'(1);
            i_nxt     = '0;
            j_nxt     = '0;
            base_nxt  = '0;
            state_nxt = S_BRD;
          end else begin
            state_nxt = S_FILL;
          end
        end
      end
      S_BRD: begin
        cs_re     = 1'b1;
        cs_raddr  = hi_addr;
        tw_re     = 1'b1;
        state_nxt = S_BHI;
      end
      S_BHI: begin
        hi_nxt    = cs_rdata;
        s_nxt     = tw_rdata;
        cs_re     = 1'b1;
        cs_raddr  = lo_addr;
        state_nxt = S_BLO;
      end
      S_BLO: begin
        mm_start = 1'b1;
        if (fwd_r) begin
          u_nxt     = cs_rdata;
          mm_reduce = 1'b1;
          mm_a      = hi_r;
          mm_b      = s_r;
          state_nxt = S_FW1;
        end else begin
          mm_reduce = 1'b1;
          mm_a      = cs_rdata;
          mm_b      = WORD_BITS'(1);
          state_nxt = S_IV1;
        end
      end
      S_FW1: begin
        if (!mm_busy_r) begin
          v_nxt     = mm_res;
          mm_start  = 1'b1;
          mm_reduce = 1'b1;
          mm_a      = u_r;
          mm_b      = WORD_BITS'(1);
          state_nxt = S_FW2;
        end
      end
      S_FW2: begin
        if (!mm_busy_r) begin
          u_nxt     = mm_res;
          state_nxt = S_WLO;
        end
      end
      S_IV1: begin
        if (!mm_busy_r) begin
          u_nxt     = mm_res;
          mm_start  = 1'b1;
          mm_reduce = 1'b1;
          mm_a      = hi_r;
          mm_b      = WORD_BITS'(1);
          state_nxt = S_IV2;
        end
      end
      S_IV2: begin
        if (!mm_busy_r) begin
          v_nxt     = mm_res;
          state_nxt = S_IV3;
        end
      end
      S_IV3: begin
        mm_start  = 1'b1;
        mm_a      = diff_c;
        mm_b      = s_r;
        state_nxt = S_IV4;
      end
      S_IV4: begin
        if (!mm_busy_r) begin
          state_nxt = S_WLO;
        end
      end
      S_WLO: begin
        cs_we     = 1'b1;
        cs_waddr  = lo_addr;
        cs_wdata  = sum_c;
        state_nxt = S_WHI;
      end
      S_WHI: begin
        cs_we     = 1'b1;
        cs_waddr  = hi_addr;
        cs_wdata  = fwd_r ? diff_c : mm_res;
        state_nxt = S_BRD;
        if (!last_j) begin
          j_nxt = j_r + 1'b1;
        end else begin
          j_nxt    = '0;
          base_nxt = base_r + (t_r << 1);
          if (!last_i) begin
            i_nxt = i_r + 1'b1;
          end else begin
            i_nxt    = '0;
            base_nxt = '0;
            if (fwd_r) begin
              g_nxt = g_r << 1;
              t_nxt = t_r >> 1;
              if (t_r == CW'(1)) begin
                state_nxt = S_DONE;
              end
            end else begin
              g_nxt = g_r >> 1;
              t_nxt = t_r << 1;
              if (g_r == CW'(1)) begin
                j_nxt     = '0;
                state_nxt = S_SC0;
              end
            end
          end
        end
      end
      S_SC0: begin
        cs_re     = 1'b1;
        cs_raddr  = AW'(j_r);
        state_nxt = S_SC1;
      end
      S_SC1: begin
        mm_start  = 1'b1;
        mm_reduce = 1'b1;
        mm_a      = cs_rdata;
        mm_b      = size_inv_r;
        state_nxt = S_SC2;
      end
      S_SC2: begin
        if (!mm_busy_r) begin
          cs_we    = 1'b1;
          cs_waddr = AW'(j_r);
          cs_wdata = mm_res;
          j_nxt    = j_r + 1'b1;
          if (j_r == n_eff - 1'b1) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SC0;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.coeff_out = '0;
          out_data_nxt.kind      = KIND_DONE;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r      <= fwd_nxt;
    rd_oob_r   <= rd_oob_nxt;
    k_r        <= k_nxt;
    g_r        <= g_nxt;
    t_r        <= t_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    p_r        <= p_nxt;
    hi_r       <= hi_nxt;
    s_r        <= s_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/nne_checker.sv
// port-level checker for the negacyclic ntt engine and its bind
module nne_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input nne_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input nne_pkg::out_item_t out_data
);

  import nne_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // read or transform closes the input in the cycle after its transfer
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd != CMD_WRITE) |=> !in_ready)
    else $error("input open right after a read or transform transfer");

  // done marker carries zero data
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_DONE) |-> out_data.coeff_out == '0)
    else $error("done result with nonzero data");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind negacyclic_ntt_engine nne_checker u_nne_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
